[rtl/mrtu_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the Modbus RTU responder.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int HDR_BYTES     = 9;
   localparam int DESC_BYTES    = 6;
   localparam int QUEUE_DEPTH   = 4;

   // Function codes
   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;

   // Exception codes
   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
   localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;
   localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'd4;

   // Register addresses and the quantities they accept
   localparam logic [15:0] REG_DEVICE_ID = 16'd1001;
   localparam logic [15:0] REG_BLOCK_A   = 16'd1002;
   localparam logic [15:0] REG_BLOCK_B   = 16'd1010;
   localparam logic [15:0] QTY_DEVICE_ID = 16'd1;
   localparam logic [15:0] QTY_BLOCK_A   = 16'd8;
   localparam logic [15:0] QTY_BLOCK_B   = 16'd20;

   // Byte-count fields of read answers and of a write request
   localparam logic [7:0] BC_DEVICE_ID = 8'h02;
   localparam logic [7:0] BC_BLOCK_A   = 8'h10;
   localparam logic [7:0] BC_BLOCK_B   = 8'h28;
   localparam logic [7:0] BC_WRITE_ID  = 8'h02;

   // Frame length limits
   localparam logic [7:0] MIN_FRAME_LEN   = 8'd4;
   localparam logic [7:0] READ_FRAME_LEN  = 8'd8;
   localparam logic [7:0] WRITE_FRAME_MIN = 8'd11;

   // Response body lengths, CRC not included
   localparam int LEN_W = 6;
   localparam logic [LEN_W-1:0] LEN_EXCEPTION  = 6'd3;
   localparam logic [LEN_W-1:0] LEN_READ_ID    = 6'd5;
   localparam logic [LEN_W-1:0] LEN_READ_A     = 6'd19;
   localparam logic [LEN_W-1:0] LEN_READ_B     = 6'd43;
   localparam logic [LEN_W-1:0] LEN_WRITE_ECHO = 6'd6;

   localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_array_type;

   // Frame-end summary handed from the receive side to the decoder
   typedef struct packed {
      logic       valid;
      logic [7:0] len;
      logic       crc_ok;
   } frame_done_type;

   // One queued response: leading bytes, the rest of the body is zero
   typedef struct packed {
      logic [LEN_W-1:0]               len;
      logic [DESC_BYTES-1:0][7:0]     body;
   } resp_desc_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/mrtu_rx_front.sv]
// Receive side: running CRC, header capture, byte count and frame-end summary.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_rx_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   frame_end,
   output mrtu_pkg::hdr_array_type     hdr,
   output mrtu_pkg::frame_done_type    done
);
   import mrtu_pkg::*;

   logic [15:0]    crc_ff, crc_in, crc_next;
   logic [7:0]     tail0_ff, tail0_in, tail1_ff, tail1_in;
   logic [7:0]     count_ff, count_in, count_sat;
   hdr_array_type  hdr_ff, hdr_in;
   frame_done_type done_ff, done_in;

   always_comb begin
      crc_in    = crc_ff;
      tail0_in  = tail0_ff;
      tail1_in  = tail1_ff;
      count_in  = count_ff;
      hdr_in    = hdr_ff;
      done_in   = '0;
      crc_next  = (count_ff >= 8'd2) ? crc_byte(crc_ff, tail0_ff) : crc_ff;
      count_sat = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
      if (accept) begin
         if (count_ff < 8'(HDR_BYTES)) begin
            hdr_in[count_ff[3:0]] = rx_byte;
         end
         if (frame_end) begin
            done_in.valid  = 1'b1;
            done_in.len    = count_sat;
            done_in.crc_ok = ({rx_byte, tail1_ff} == crc_next);
            // drop frame state, header stays for the decoder
            crc_in   = CRC_INIT;
            tail0_in = 8'h00;
            tail1_in = 8'h00;
            count_in = 8'h00;
         end else begin
            crc_in   = crc_next;
            tail0_in = tail1_ff;
            tail1_in = rx_byte;
            count_in = count_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         tail0_ff <= 8'h00;
         tail1_ff <= 8'h00;
         count_ff <= 8'h00;
         done_ff  <= '0;
      end else begin
         crc_ff   <= crc_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   assign hdr  = hdr_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

[rtl/mrtu_classify.sv]
// Frame decoder: address and CRC checks, function dispatch, live device id.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_classify (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  mrtu_pkg::frame_done_type    done,
   input  mrtu_pkg::hdr_array_type     hdr,
   input  wire logic                   csr_write,
   input  wire logic [7:0]             csr_id,
   output logic                        push,
   output mrtu_pkg::resp_desc_type     desc
);
   import mrtu_pkg::*;

   logic [7:0]  dev_id_ff, dev_id_in;
   logic [7:0]  func;
   logic [15:0] addr, qty;
   logic        is_exc;
   logic [7:0]  exc_code;

   assign func = hdr[1];
   assign addr = {hdr[2], hdr[3]};
   assign qty  = {hdr[4], hdr[5]};

   always_comb begin
      push      = 1'b0;
      desc      = '0;
      dev_id_in = dev_id_ff;
      is_exc    = 1'b0;
      exc_code  = EXC_ILLEGAL_FUNCTION;
      if (done.valid && done.len >= MIN_FRAME_LEN && hdr[0] == dev_id_ff && done.crc_ok) begin
         push         = 1'b1;
         desc.body[0] = dev_id_ff;
         desc.body[1] = func;
         case (func)
            FC_READ_HOLDING: begin
               if (done.len != READ_FRAME_LEN) begin
                  is_exc   = 1'b1;
                  exc_code = EXC_DEVICE_FAILURE;
               end else begin
                  case (addr)
                     REG_DEVICE_ID: begin
                        is_exc       = (qty != QTY_DEVICE_ID);
                        exc_code     = EXC_ILLEGAL_VALUE;
                        desc.body[2] = BC_DEVICE_ID;
                        desc.body[4] = dev_id_ff;
                        desc.len     = LEN_READ_ID;
                     end
                     REG_BLOCK_A: begin
                        is_exc       = (qty != QTY_BLOCK_A);
                        exc_code     = EXC_ILLEGAL_VALUE;
                        desc.body[2] = BC_BLOCK_A;
                        desc.len     = LEN_READ_A;
                     end
                     REG_BLOCK_B: begin
                        is_exc       = (qty != QTY_BLOCK_B);
                        exc_code     = EXC_ILLEGAL_VALUE;
                        desc.body[2] = BC_BLOCK_B;
                        desc.len     = LEN_READ_B;
                     end
                     default: begin
                        is_exc   = 1'b1;
                        exc_code = EXC_ILLEGAL_ADDRESS;
                     end
                  endcase
               end
            end
            FC_WRITE_MULTI: begin
               if (done.len < WRITE_FRAME_MIN) begin
                  is_exc   = 1'b1;
                  exc_code = EXC_DEVICE_FAILURE;
               end else if (addr != REG_DEVICE_ID) begin
                  // unsupported write target is silently dropped
                  push = 1'b0;
               end else if (qty != QTY_DEVICE_ID) begin
                  is_exc   = 1'b1;
                  exc_code = EXC_ILLEGAL_VALUE;
               end else if (hdr[6] != BC_WRITE_ID) begin
                  is_exc   = 1'b1;
                  exc_code = EXC_DEVICE_FAILURE;
               end else begin
                  dev_id_in    = hdr[8];
                  desc.body[0] = hdr[8];
                  desc.body[2] = hdr[2];
                  desc.body[3] = hdr[3];
                  desc.body[4] = hdr[4];
                  desc.body[5] = hdr[5];
                  desc.len     = LEN_WRITE_ECHO;
               end
            end
            default: begin
               is_exc   = 1'b1;
               exc_code = EXC_ILLEGAL_FUNCTION;
            end
         endcase
         if (is_exc) begin
            desc         = '0;
            desc.body[0] = dev_id_ff;
            desc.body[1] = func + FC_EXCEPTION_BIT;
            desc.body[2] = exc_code;
            desc.len     = LEN_EXCEPTION;
         end
      end
      if (csr_write) begin
         dev_id_in = csr_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_id_ff <= DEVICE_ID_RESET;
      end else begin
         dev_id_ff <= dev_id_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mrtu_resp_fifo.sv]
// Small queue of response descriptors between the decoder and the transmit side.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_resp_fifo #(
   parameter int DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  mrtu_pkg::resp_desc_type       push_desc,
   input  wire logic                     pop,
   output mrtu_pkg::resp_desc_type       head,
   output logic                          empty,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import mrtu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   resp_desc_type    mem [DEPTH];
   resp_desc_type    head_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
      // fetch the next head; a word landing in that slot passes straight through
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_desc;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head  = head_ff;
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

`default_nettype wire

[rtl/mrtu_tx_back.sv]
// Transmit side: expands a descriptor into response words and appends the CRC.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_tx_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  mrtu_pkg::resp_desc_type   head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import mrtu_pkg::*;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             load;
   logic [7:0]       body_byte;

   assign load = !empty && (!valid_ff || rsp_tready);

   always_comb begin
      body_byte = 8'h00;
      if (idx_ff < LEN_W'(DESC_BYTES)) begin
         body_byte = head.body[idx_ff[2:0]];
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         idx_in   = idx_ff + LEN_W'(1);
         if (idx_ff < head.len) begin
            byte_in = body_byte;
            crc_in  = crc_byte(crc_ff, body_byte);
         end else if (idx_ff == head.len) begin
            byte_in = crc_ff[7:0];
         end else begin
            // high CRC byte closes the response
            byte_in = crc_ff[15:8];
            last_in = 1'b1;
            idx_in  = '0;
            crc_in  = CRC_INIT;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

[rtl/modbus_rtu_slave_frame_responder.sv]
// Top level of the Modbus RTU slave frame responder.
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU slave: received frame bytes come in as words on req_ (tlast on the
// final byte of a frame) and responses leave as words on rsp_, CRC low byte before
// high byte, tlast on the final byte. The receive side takes one word every clock
// while req_tready is high; its CRC-16/MODBUS update is a single byte step per
// cycle. In the cycle after a frame end the decoder checks length, station address
// and CRC and queues a response descriptor; frames that are short, foreign or
// corrupt, and writes to unsupported addresses, produce nothing. Supported: read
// holding registers at 1001 (device id), 1002 (8 zero registers), 1010 (20 zero
// registers), and write multiple to 1001, which replaces the station address.
// Other requests get an exception response with code 1 to 4. The transmit side
// sends one word per cycle while rsp_tready is high, so a response of N body
// bytes leaves as N+2 words; the descriptor queue (QUEUE_DEPTH entries) lets bytes
// of later frames flow in while earlier responses drain. req_tready drops only
// when the queue has no free entry left for a frame end. A write on csr_ loads
// the station address; issue it only while the block is idle.
module modbus_rtu_slave_frame_responder #(
   parameter int QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] rx_byte
   input  wire logic       req_tlast,    // frame_end
   // response stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] tx_byte
   output logic            rsp_tlast,    // tx_last
   // station address write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_wdata     // [7:0] initial_device_id
);
   import mrtu_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic             req_accept;
   hdr_array_type    hdr;
   frame_done_type   done;
   logic             push;
   resp_desc_type    push_desc;
   resp_desc_type    head;
   logic             empty;
   logic             pop;
   logic [CNT_W-1:0] q_count;
   logic [CNT_W:0]   q_reserved;

   // Reserve a queue entry for a frame end already accepted but not yet decoded
   assign q_reserved = {1'b0, q_count} + (CNT_W+1)'(done.valid);
   assign req_tready = (q_reserved < (CNT_W+1)'(QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   mrtu_rx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_tdata),
      .frame_end (req_tlast),
      .hdr       (hdr),
      .done      (done)
   );

   mrtu_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .done      (done),
      .hdr       (hdr),
      .csr_write (csr_valid && csr_ready),
      .csr_id    (csr_wdata),
      .push      (push),
      .desc      (push_desc)
   );

   mrtu_resp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .count     (q_count)
   );

   mrtu_tx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
